### rtl/gps_pkg.sv
// Shared types, constants and elaboration-time helpers for the Gaussian point smoother.
// Holds the point and MAC command types and the coefficient table generator.
// No dependencies.
package gps_pkg;

  localparam int DEF_MAX_WIDTH = 8;
  localparam int DEF_COEF_BITS = 18;
  localparam int COORD_BITS    = 32;
  localparam int WIDTH_BITS    = 4;
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 4'd4;
  localparam int SERIES_TERMS  = 12;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // One stored point; x sits in the lowest bits, matching the stream packing.
  typedef struct packed {
    coord_t t;
    coord_t y;
    coord_t x;
  } point_t;

  typedef struct packed {
    logic acc_clear;
    logic tap_valid;
  } mac_cmd_t;

  // Restoring long division, used only while building constant tables.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-num/den) in Q2.30: series for exp(-x/4), then squared twice.
  function automatic logic [63:0] exp_neg(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] term;
    logic [63:0] sum;
    term = Q30_ONE;
    sum  = Q30_ONE;
    for (int n = 1; n <= SERIES_TERMS; n++) begin
      term = udiv64(term * num, (den * 64'(n)) << 2);
      if ((n % 2) == 1) sum = sum - term;
      else sum = sum + term;
    end
    sum = (sum * sum + (Q30_ONE >> 1)) >> 30;
    sum = (sum * sum + (Q30_ONE >> 1)) >> 30;
    return sum;
  endfunction

  // Normalized tap weight j of a window with half-width w, cb fraction bits.
  function automatic logic [63:0] coef_calc(input int w, input int j, input int cb);
    logic [63:0] total;
    logic [63:0] raw_j;
    logic [63:0] raw;
    total = '0;
    raw_j = '0;
    if (w == 0) return (j == 0) ? (64'd1 << cb) : 64'd0;
    if (j > w) return 64'd0;
    for (int k = 0; k <= w; k++) begin
      raw = exp_neg(64'(3 * k * k), 64'(w * w));
      if (k == j) raw_j = raw;
      total = total + ((k == 0) ? raw : (raw << 1));
    end
    return udiv64((raw_j << cb) + (total >> 1), total);
  endfunction

endpackage

### rtl/gps_ring_ram.sv
// Point ring buffer of the Gaussian point smoother: one write and one registered read port.
// Depends on gps_pkg for the point type.
module gps_ring_ram
  import gps_pkg::*;
#(
  parameter int DEPTH = 2 * DEF_MAX_WIDTH + 1,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  point_t        wr_data,
  input  logic [AW-1:0] rd_addr,
  output point_t        rd_data
);

  point_t mem_r [DEPTH];
  point_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/gps_mac.sv
// Three-lane multiply-accumulate unit with rounding and saturation to Q16.16.
// Depends on gps_pkg for the point and command types.
module gps_mac
  import gps_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int COEF_BITS = DEF_COEF_BITS,
  localparam int COEF_W = COEF_BITS + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mac_cmd_t          cmd,
  input  logic [COEF_W-1:0] coef,
  input  point_t            rd_data,
  output logic              busy,
  output point_t            sat_point
);

  localparam int DEPTH  = 2 * MAX_WIDTH + 1;
  localparam int PROD_W = COORD_BITS + COEF_W + 1;
  localparam int ACC_W  = PROD_W + $clog2(DEPTH);
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'd1 << (COEF_BITS - 1));
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO =
    {{(ACC_W - COORD_BITS + 1){1'b1}}, {(COORD_BITS - 1){1'b0}}};

  logic                     v1_r;
  logic                     v2_r;
  logic [COEF_W-1:0]        coef_r;
  logic signed [PROD_W-1:0] prod_r [3];
  logic signed [ACC_W-1:0]  acc_r  [3];
  logic signed [ACC_W-1:0]  rnd    [3];
  logic signed [ACC_W-1:0]  shr    [3];
  coord_t                   lane_in  [3];
  coord_t                   lane_out [3];

  always_comb begin
    lane_in[0] = rd_data.x;
    lane_in[1] = rd_data.y;
    lane_in[2] = rd_data.t;
  end

  // Stage 1: memory data and coefficient line up; stage 2: product; then accumulate.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.tap_valid;
      v2_r <= v1_r;
    end
    coef_r <= coef;
    for (int l = 0; l < 3; l++) begin
      prod_r[l] <= lane_in[l] * $signed({1'b0, coef_r});
      if (cmd.acc_clear) begin
        acc_r[l] <= '0;
      end else if (v2_r) begin
        acc_r[l] <= acc_r[l] + ACC_W'(prod_r[l]);
      end
    end
  end

  // Round half up, floor shift, clamp to the signed coordinate range.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rnd[l] = acc_r[l] + RND_HALF;
      shr[l] = rnd[l] >>> COEF_BITS;
      if (shr[l] > SAT_HI) begin
        lane_out[l] = SAT_HI[COORD_BITS-1:0];
      end else if (shr[l] < SAT_LO) begin
        lane_out[l] = SAT_LO[COORD_BITS-1:0];
      end else begin
        lane_out[l] = shr[l][COORD_BITS-1:0];
      end
    end
  end

  assign sat_point.x = lane_out[0];
  assign sat_point.y = lane_out[1];
  assign sat_point.t = lane_out[2];
  assign busy        = v1_r | v2_r;

endmodule

### rtl/gps_ctrl.sv
// Sequencer of the Gaussian point smoother: ring bookkeeping, tap walk, coefficient table,
// width register and output register. Depends on gps_pkg.
module gps_ctrl
  import gps_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int COEF_BITS = DEF_COEF_BITS,
  localparam int DEPTH  = 2 * MAX_WIDTH + 1,
  localparam int AW     = $clog2(DEPTH),
  localparam int COEF_W = COEF_BITS + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [WIDTH_BITS-1:0] cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  in_tlast,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output logic [AW-1:0]         rd_addr,
  output logic [COEF_W-1:0]     coef,
  output mac_cmd_t              mac_cmd,
  input  logic                  mac_busy,
  input  point_t                sat_point,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output point_t                out_tdata,
  output logic                  out_tlast
);

  localparam int SEEN_SAT = 2 * MAX_WIDTH + 2;
  localparam int SW       = $clog2(SEEN_SAT + 1);
  localparam int PW       = $clog2(MAX_WIDTH + 2);
  localparam int WW       = $clog2(MAX_WIDTH + 1);
  localparam int ROWS     = MAX_WIDTH + 1;
  localparam int TAB_N    = ROWS * ROWS;
  localparam int TIW      = $clog2(TAB_N);
  localparam int TAB_BITS = TAB_N * COEF_W;

  function automatic logic [TAB_BITS-1:0] build_tab();
    logic [TAB_BITS-1:0] tab;
    tab = '0;
    for (int w = 0; w < ROWS; w++) begin
      for (int j = 0; j < ROWS; j++) begin
        tab[(w * ROWS + j) * COEF_W +: COEF_W] = COEF_W'(coef_calc(w, j, COEF_BITS));
      end
    end
    return tab;
  endfunction

  localparam logic [TAB_BITS-1:0] COEF_TAB = build_tab();

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_TAP,
    ST_DRAIN,
    ST_OUT
  } state_t;

  state_t                state_r, state_nxt;
  logic [WIDTH_BITS-1:0] width_cfg_r, width_cfg_nxt;
  logic [SW-1:0]         seen_r, seen_nxt;
  logic [PW-1:0]         pend_r, pend_nxt;
  logic [AW-1:0]         ne_r, ne_nxt;
  logic [WW-1:0]         cw_r, cw_nxt;
  logic                  flush_r, flush_nxt;
  logic [WW-1:0]         w_r, w_nxt;
  logic signed [WW:0]    tap_j_r, tap_j_nxt;
  logic [AW-1:0]         addr_r, addr_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_last_r, out_last_nxt;
  point_t                out_data_r, out_data_nxt;

  logic                  first;
  logic [WW-1:0]         cw_new;
  logic [WW-1:0]         cw_eff;
  logic [PW-1:0]         pend_eff;
  logic [PW-1:0]         pend_inc;
  logic [SW-1:0]         seen_inc;
  logic [AW:0]           slot_sum;
  logic [SW-1:0]         idx;
  logic [SW-1:0]         pm1;
  logic [SW-1:0]         w_min;
  logic [WW-1:0]         w_set;
  logic [AW:0]           start_sum;
  logic [AW-1:0]         start_slot;
  logic [WW-1:0]         j_abs;
  logic [TIW-1:0]        tab_idx;
  logic                  tap_last;
  logic [AW-1:0]         addr_inc;
  logic [AW-1:0]         ne_inc;
  logic                  out_free;
  logic                  flush_done;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_free   = !out_valid_r || out_tready;
  assign flush_done = flush_r && (pend_r == PW'(1));

  always_comb begin
    // Arrival bookkeeping; a new curve latches its width and starts an empty ring run.
    first    = (seen_r == '0);
    cw_new   = (32'(width_cfg_r) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(width_cfg_r);
    cw_eff   = first ? cw_new : cw_r;
    pend_eff = first ? '0 : pend_r;
    pend_inc = pend_eff + PW'(1);
    seen_inc = (seen_r == SW'(SEEN_SAT)) ? seen_r : seen_r + SW'(1);
    slot_sum = {1'b0, ne_r} + (AW + 1)'(pend_eff);
    wr_addr  = (slot_sum >= (AW + 1)'(DEPTH)) ? AW'(slot_sum - (AW + 1)'(DEPTH))
                                               : AW'(slot_sum);
    wr_en    = in_tvalid && in_tready;

    // Half-width of the point being emitted: limited by both curve ends and the width.
    idx   = seen_r - SW'(pend_r);
    pm1   = SW'(pend_r - PW'(1));
    w_min = (idx < pm1) ? idx : pm1;
    if (SW'(cw_r) < w_min) w_min = SW'(cw_r);
    w_set      = WW'(w_min);
    start_sum  = {1'b0, ne_r} + (AW + 1)'(DEPTH) - (AW + 1)'(w_set);
    start_slot = (start_sum >= (AW + 1)'(DEPTH)) ? AW'(start_sum - (AW + 1)'(DEPTH))
                                                  : AW'(start_sum);

    // Tap walk from -w to +w; the table is symmetric so only |j| is looked up.
    j_abs    = tap_j_r[WW] ? WW'(-tap_j_r) : WW'(tap_j_r);
    tab_idx  = TIW'(32'(w_r) * ROWS + 32'(j_abs));
    coef     = COEF_TAB[tab_idx * COEF_W +: COEF_W];
    tap_last = (tap_j_r == $signed({1'b0, w_r}));
    addr_inc = (addr_r == AW'(DEPTH - 1)) ? '0 : addr_r + AW'(1);
    ne_inc   = (ne_r == AW'(DEPTH - 1)) ? '0 : ne_r + AW'(1);
    rd_addr  = addr_r;
  end

  always_comb begin
    state_nxt     = state_r;
    width_cfg_nxt = width_cfg_r;
    seen_nxt      = seen_r;
    pend_nxt      = pend_r;
    ne_nxt        = ne_r;
    cw_nxt        = cw_r;
    flush_nxt     = flush_r;
    w_nxt         = w_r;
    tap_j_nxt     = tap_j_r;
    addr_nxt      = addr_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    out_data_nxt  = out_data_r;
    mac_cmd       = '0;

    if (cfg_valid) width_cfg_nxt = cfg_data;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cw_nxt    = cw_eff;
          pend_nxt  = pend_inc;
          seen_nxt  = seen_inc;
          flush_nxt = in_tlast;
          if (in_tlast || (32'(pend_inc) > 32'(cw_eff))) state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        w_nxt             = w_set;
        tap_j_nxt         = -$signed({1'b0, w_set});
        addr_nxt          = start_slot;
        mac_cmd.acc_clear = 1'b1;
        state_nxt         = ST_TAP;
      end
      ST_TAP: begin
        mac_cmd.tap_valid = 1'b1;
        addr_nxt          = addr_inc;
        tap_j_nxt         = tap_j_r + $signed((WW + 1)'(1));
        if (tap_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!mac_busy) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = sat_point;
          out_last_nxt  = flush_done;
          pend_nxt      = pend_r - PW'(1);
          ne_nxt        = ne_inc;
          if (!flush_r) begin
            state_nxt = ST_IDLE;
          end else if (flush_done) begin
            state_nxt = ST_IDLE;
            seen_nxt  = '0;
            ne_nxt    = '0;
          end else begin
            state_nxt = ST_SETUP;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      width_cfg_r <= WIDTH_RESET;
      seen_r      <= '0;
      pend_r      <= '0;
      ne_r        <= '0;
      cw_r        <= '0;
      flush_r     <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      width_cfg_r <= width_cfg_nxt;
      seen_r      <= seen_nxt;
      pend_r      <= pend_nxt;
      ne_r        <= ne_nxt;
      cw_r        <= cw_nxt;
      flush_r     <= flush_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
    w_r        <= w_nxt;
    tap_j_r    <= tap_j_nxt;
    addr_r     <= addr_nxt;
    out_data_r <= out_data_nxt;
  end

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pend_r) <= MAX_WIDTH + 1)
    else $error("pending point count exceeds the window");

  a_last_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> (state_r == ST_SETUP))
    else $error("final point did not start a flush");

  a_curve_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_free && flush_done) |=> (seen_r == '0 && ne_r == '0))
    else $error("curve state not cleared after final result");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mac_busy)
    else $error("MAC pipeline busy while idle");

  a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TAP) |-> (tap_j_r <= $signed({1'b0, w_r})))
    else $error("tap index ran past the window");

endmodule

### rtl/gaussian_point_smoother.sv
// Gaussian point smoother: result i = (2w+1)-tap Gaussian mean of stored points, one tap a cycle.
// A point is taken only while idle; one causing no result is stored and the block stays idle.
// A result goes through setup, the tap walk, MAC drain and output register. The tap walk,
// one ring memory read and one three-lane MAC per cycle, sets the rate unless the output stalls.
// Reset: synchronous, active low; clears counters and handshakes, width register to 4.
// The ring memory is not cleared; only points of the current curve are ever read.
//
// Depends on gps_pkg, gps_ring_ram, gps_mac and gps_ctrl.
module gaussian_point_smoother
  import gps_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int COEF_BITS = DEF_COEF_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration: window_width, the largest half-width of the smoothing window.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [WIDTH_BITS-1:0] cfg_data,
  // Input points.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [95:0]           in_tdata,   // coord_x [31:0], coord_y [63:32], coord_t [95:64]
  input  logic                  in_tlast,   // last_point
  // Smoothed points.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [95:0]           out_tdata,  // smooth_x [31:0], smooth_y [63:32], smooth_t [95:64]
  output logic                  out_tlast   // last_result
);

  localparam int DEPTH  = 2 * MAX_WIDTH + 1;
  localparam int AW     = $clog2(DEPTH);
  localparam int COEF_W = COEF_BITS + 1;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  point_t            rd_data;
  point_t            wr_point;
  point_t            out_point;
  point_t            sat_point;
  logic [COEF_W-1:0] coef;
  mac_cmd_t          mac_cmd;
  logic              mac_busy;

  // Each point is written into the ring on the transaction that carries it.
  assign wr_point  = point_t'(in_tdata);
  assign out_tdata = out_point;

  // The ring holds the last 2*MAX_WIDTH+1 points of the curve, enough for a full window.
  gps_ring_ram #(
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_point),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Products and sums for x, y and t run side by side; rounding and clamping are at the end.
  gps_mac #(
    .MAX_WIDTH (MAX_WIDTH),
    .COEF_BITS (COEF_BITS)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (mac_cmd),
    .coef      (coef),
    .rd_data   (rd_data),
    .busy      (mac_busy),
    .sat_point (sat_point)
  );

  // The sequencer accepts a point only when no result is being computed, but the output
  // register lets the next point in while a finished result still waits downstream.
  gps_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .COEF_BITS (COEF_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tlast   (in_tlast),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr),
    .coef       (coef),
    .mac_cmd    (mac_cmd),
    .mac_busy   (mac_busy),
    .sat_point  (sat_point),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_point),
    .out_tlast  (out_tlast)
  );

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for gaussian_point_smoother: streams polylines, predicts every smoothed
// point with a local fixed-point model and compares each output transaction field by field.
// Depends on gps_pkg and the RTL top level only.
module testbench;
  import gps_pkg::*;

  localparam int MAXW          = DEF_MAX_WIDTH;
  localparam int CBITS         = DEF_COEF_BITS;
  localparam int RING          = 2 * MAXW + 1;
  localparam int SEEN_CAP      = 2 * MAXW + 2;
  localparam int DRAIN_CYCLES  = 4 * MAXW + 12;
  localparam int RANDOM_ITEMS  = 410;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 60;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int DIRECTED_ROWS = 28;

  typedef enum logic [1:0] {ROW_CFG, ROW_PREDICT, ROW_TYPED} row_kind_t;

  // One smoothed point as it leaves the block.
  typedef struct packed {
    logic   last;
    point_t pt;
  } smooth_result_t;

  // Directed stimulus row. ROW_TYPED rows carry their expected output; ROW_PREDICT
  // rows are checked against the predictor; ROW_CFG rows write the window width.
  typedef struct {
    row_kind_t       kind;
    logic [3:0]      width;
    coord_t          x, y, t;
    logic            last;
    coord_t          want_x, want_y, want_t;
    logic            want_last;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [WIDTH_BITS-1:0] cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [95:0]           in_tdata = '0;   // coord_x [31:0], coord_y [63:32], coord_t [95:64]
  logic                  in_tlast = 1'b0; // last_point
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [95:0]           out_tdata;       // smooth_x [31:0], smooth_y [63:32], smooth_t [95:64]
  logic                  out_tlast;       // last_result

  gaussian_point_smoother uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: Gaussian tap weights, the point ring and the curve counters.
  // ---------------------------------------------------------------------------
  longint unsigned tap_weight [0:MAXW][0:MAXW];
  coord_t          ring_x [RING];
  coord_t          ring_y [RING];
  coord_t          ring_t [RING];
  int unsigned     seen_count;
  int unsigned     head_slot;
  int unsigned     pending_pts;
  int unsigned     curve_half;
  int unsigned     width_reg;

  smooth_result_t  step_out [$];
  smooth_result_t  expected_points [$];
  int unsigned     fail_count;
  int unsigned     results_seen;
  int unsigned     cycle_count;
  bit              sender_steady;

  // exp(-num/den) in Q2.30: twelve terms of the series for exp(-x/4), squared twice.
  function automatic longint unsigned gauss_raw(longint unsigned num, longint unsigned den);
    longint unsigned term;
    longint unsigned acc;
    term = 64'd1 << 30;
    acc  = term;
    for (int n = 1; n <= SERIES_TERMS; n++) begin
      term = term * num / (64'd4 * den * 64'(n));
      if (n % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    acc = (acc * acc + (64'd1 << 29)) >> 30;
    acc = (acc * acc + (64'd1 << 29)) >> 30;
    return acc;
  endfunction

  function automatic void build_weights();
    longint unsigned raw [0:MAXW];
    longint unsigned total;
    for (int w = 0; w <= MAXW; w++)
      for (int j = 0; j <= MAXW; j++) tap_weight[w][j] = 0;
    tap_weight[0][0] = 64'd1 << CBITS;
    for (int w = 1; w <= MAXW; w++) begin
      total = 0;
      for (int j = 0; j <= w; j++) begin
        raw[j] = gauss_raw(64'(3 * j * j), 64'(w * w));
        total  = total + ((j == 0) ? raw[j] : 2 * raw[j]);
      end
      for (int j = 0; j <= w; j++)
        tap_weight[w][j] = ((raw[j] << CBITS) + total / 2) / total;
    end
  endfunction

  // Round the Q.18-scaled sum back to Q16.16 and clamp to the 32-bit signed range.
  function automatic coord_t saturate_q(longint acc);
    longint r;
    r = (acc + (longint'(1) << (CBITS - 1))) >>> CBITS;
    if (r > 64'sd2147483647) return 32'h7FFFFFFF;
    if (r < -64'sd2147483648) return 32'h80000000;
    return coord_t'(r);
  endfunction

  // Weighted mean around the oldest pending point; the half-width shrinks near both ends.
  function automatic smooth_result_t emit_smoothed();
    int unsigned    idx;
    int unsigned    w;
    int             slot;
    longint         c;
    longint         acc_x, acc_y, acc_t;
    smooth_result_t res;
    idx   = seen_count - pending_pts;
    w     = pending_pts - 1;
    acc_x = 0;
    acc_y = 0;
    acc_t = 0;
    if (idx < w) w = idx;
    if (curve_half < w) w = curve_half;
    for (int j = -int'(w); j <= int'(w); j++) begin
      slot  = (int'(head_slot) + 2 * RING + j) % RING;
      c     = longint'(tap_weight[w][(j < 0) ? -j : j]);
      acc_x = acc_x + c * longint'(ring_x[slot]);
      acc_y = acc_y + c * longint'(ring_y[slot]);
      acc_t = acc_t + c * longint'(ring_t[slot]);
    end
    res.pt.x  = saturate_q(acc_x);
    res.pt.y  = saturate_q(acc_y);
    res.pt.t  = saturate_q(acc_t);
    res.last  = 1'b0;
    head_slot = (head_slot + 1) % RING;
    pending_pts--;
    return res;
  endfunction

  // Advance the predictor by one accepted point; the results it causes land in step_out.
  task automatic smooth_step(input point_t pt, input logic last);
    int unsigned    slot;
    smooth_result_t tail;
    step_out.delete();
    if (seen_count == 0) begin
      // The width is latched at the first point of each curve.
      curve_half  = (width_reg > MAXW) ? MAXW : width_reg;
      head_slot   = head_slot % RING;
      pending_pts = 0;
    end
    slot         = (head_slot + pending_pts) % RING;
    ring_x[slot] = pt.x;
    ring_y[slot] = pt.y;
    ring_t[slot] = pt.t;
    pending_pts++;
    if (seen_count < SEEN_CAP) seen_count++;
    if (last) begin
      // The last point flushes every result still due.
      while (pending_pts > 0) step_out.push_back(emit_smoothed());
      tail      = step_out.pop_back();
      tail.last = 1'b1;
      step_out.push_back(tail);
      seen_count = 0;
      head_slot  = 0;
    end else if (pending_pts > curve_half) begin
      step_out.push_back(emit_smoothed());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Inputs change on the falling edge only.
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return coord_t'($urandom_range(0, 65535)) - 32'sd32768;
      3: return 32'h7FFF0000 + coord_t'($urandom_range(0, 65535));
      4: return 32'h80000000 + coord_t'($urandom_range(0, 65535));
      5: return '0;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Called on a falling edge; returns on a falling edge. The expectation is queued on the
  // falling edge after the accepting rising edge, so it never races the output monitor.
  task automatic send_point(input point_t pt, input logic last, input logic typed,
                            input smooth_result_t want);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tdata  <= pt;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    smooth_step(pt, last);
    if (typed) expected_points.push_back(want);
    else foreach (step_out[i]) expected_points.push_back(step_out[i]);
    gap = sender_steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Width writes happen only with the block idle: every expected point delivered and
  // enough cycles gone by for a point that caused no result to settle.
  task automatic set_width(input logic [3:0] value);
    in_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    width_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random curves: short ones mostly, a few long enough to saturate the point counter.
  // Styles: independent points, a smooth pen walk, rail-to-rail extremes.
  task automatic run_random();
    int unsigned sent;
    int unsigned phase;
    int unsigned curves;
    int unsigned len;
    int unsigned style;
    bit          t_unused;
    logic [3:0]  first_widths [6];
    logic        lst;
    point_t      p;
    sent         = 0;
    phase        = 0;
    first_widths = '{4'd0, 4'd8, 4'd15, 4'd1, 4'd12, 4'd3};
    while (sent < RANDOM_ITEMS) begin
      set_width((phase < 6) ? first_widths[phase] : 4'($urandom_range(0, 15)));
      sender_steady = ($urandom_range(0, 3) == 0);
      curves = $urandom_range(1, 4);
      for (int c = 0; c < curves; c++) begin
        len      = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
        style    = $urandom_range(0, 2);
        t_unused = ($urandom_range(0, 3) == 0);
        p        = {pick_coord(), pick_coord(), pick_coord()};
        for (int k = 0; k < len; k++) begin
          case (style)
            0: p = {pick_coord(), pick_coord(), pick_coord()};
            1: begin
              p.x = p.x + coord_t'($urandom_range(0, 262143)) - 32'sd131072;
              p.y = p.y + coord_t'($urandom_range(0, 262143)) - 32'sd131072;
              p.t = p.t + coord_t'($urandom_range(0, 65535));
            end
            default: begin
              p.x = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
              p.y = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
              p.t = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            end
          endcase
          if (t_unused) p.t = '0;
          // Now and then a phase ends mid-curve, so the next width write lands mid-curve.
          lst = (k == len - 1) && !(c == curves - 1 && $urandom_range(0, 4) == 0);
          send_point(p, lst, 1'b0, '0);
          sent++;
        end
      end
      phase++;
    end
    // Close whatever curve is still open.
    send_point({pick_coord(), pick_coord(), pick_coord()}, 1'b1, 1'b0, '0);
  endtask

  // Directed rows: reset width, width zero passing points through, extremes, saturation,
  // widths above the maximum, and a width write in the middle of a curve.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // A one-point curve comes back unchanged at the reset width.
    '{ROW_TYPED,   4'd0, 32'h00010000, 32'hFFFF0000, 32'h00000000, 1'b1,
                         32'h00010000, 32'hFFFF0000, 32'h00000000, 1'b1},
    '{ROW_PREDICT, 4'd0, 32'h00000000, 32'h00000000, 32'h00000000, 1'b0, 0, 0, 0, 1'b0},
    '{ROW_PREDICT, 4'd0, 32'h00100000, 32'h00080000, 32'h00010000, 1'b0, 0, 0, 0, 1'b0},
    '{ROW_PREDICT, 4'd0, 32'h00200000, 32'hFFF00000, 32'h00020000, 1'b1, 0, 0, 0, 1'b0},
    // Width zero: each point leaves on its own, unchanged.
    '{ROW_CFG,     4'd0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0},
    '{ROW_TYPED,   4'd0, 32'h7FFFFFFF, 32'h80000000, 32'h00000000, 1'b0,
                         32'h7FFFFFFF, 32'h80000000, 32'h00000000, 1'b0},
    '{ROW_TYPED,   4'd0, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b0,
                         32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b0},
    '{ROW_TYPED,   4'd0, 32'hFFFFFFFF, 32'h00000000, 32'h7FFFFFFF, 1'b0,
                         32'hFFFFFFFF, 32'h00000000, 32'h7FFFFFFF, 1'b0},
    '{ROW_TYPED,   4'd0, 32'h12345678, 32'hEDCBA987, 32'h80000000, 1'b1,
                         32'h12345678, 32'hEDCBA987, 32'h80000000, 1'b1},
    // Register value above the maximum acts as the maximum.
    '{ROW_CFG,     4'd15, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0},
    '{ROW_PREDICT, 4'd0, 32'h7FFFFFFF, 32'h80000000, 32'h00000000, 1'b0, 0, 0, 0, 1'b0},
    '{ROW_PREDICT, 4'd0, 32'h80000000, 32'h7FFFFFFF, 32'h00000000, 1'b0, 0, 0, 0, 1'b0},
    '{ROW_PREDICT, 4'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00010000, 1'b0, 0, 0, 0, 1'b0},
    '{ROW_PREDICT, 4'd0, 32'h80000000, 32'h80000000, 32'h00020000, 1'b0, 0, 0, 0, 1'b0},
    '{ROW_PREDICT, 4'd0, 32'h00000000, 32'h00000000, 32'h00030000, 1'b1, 0, 0, 0, 1'b0},
    // Rail values under a narrow window probe the output clamp.
    '{ROW_CFG,     4'd1, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0},
    '{ROW_PREDICT, 4'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1'b0, 0, 0, 0, 1'b0},
    '{ROW_PREDICT, 4'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1'b0, 0, 0, 0, 1'b0},
    '{ROW_PREDICT, 4'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1'b1, 0, 0, 0, 1'b0},
    // Width written mid-curve only applies from the next curve on.
    '{ROW_CFG,     4'd2, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0},
    '{ROW_PREDICT, 4'd0, 32'h00050000, 32'h00060000, 32'h00000000, 1'b0, 0, 0, 0, 1'b0},
    '{ROW_PREDICT, 4'd0, 32'h00058000, 32'h00068000, 32'h00000000, 1'b0, 0, 0, 0, 1'b0},
    '{ROW_PREDICT, 4'd0, 32'h00060000, 32'h00070000, 32'h00000000, 1'b0, 0, 0, 0, 1'b0},
    '{ROW_CFG,     4'd8, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0},
    '{ROW_PREDICT, 4'd0, 32'h00068000, 32'h00078000, 32'h00000000, 1'b0, 0, 0, 0, 1'b0},
    '{ROW_PREDICT, 4'd0, 32'h00070000, 32'h00080000, 32'h00000000, 1'b0, 0, 0, 0, 1'b0},
    '{ROW_PREDICT, 4'd0, 32'h00078000, 32'h00088000, 32'h00000000, 1'b1, 0, 0, 0, 1'b0},
    '{ROW_TYPED,   4'd0, 32'h7FFFFFFF, 32'h80000000, 32'h00000000, 1'b1,
                         32'h7FFFFFFF, 32'h80000000, 32'h00000000, 1'b1}
  };

  // ---------------------------------------------------------------------------
  // Output monitor: every output transaction is matched against the oldest expectation.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endfunction

  smooth_result_t oldest;
  point_t         seen_pt;

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready) begin
      results_seen++;
      seen_pt = out_tdata;
      if (expected_points.size() == 0) begin
        $error("output transaction with nothing expected: %h last %b", out_tdata, out_tlast);
        fail_count++;
      end else begin
        oldest = expected_points.pop_front();
        check_field("smooth_x", oldest.pt.x, seen_pt.x);
        check_field("smooth_y", oldest.pt.y, seen_pt.y);
        check_field("smooth_t", oldest.pt.t, seen_pt.t);
        check_field("last_result", 32'(oldest.last), 32'(out_tlast));
      end
    end
  end

  // Receiver: random back-pressure with quiet stretches, plus one long hold-off that lets
  // the block fill up and stall its input while the sender keeps offering points.
  initial begin : receiver
    int unsigned stall_left;
    int unsigned ticks;
    bit          held;
    bit          recv_steady;
    stall_left  = 0;
    ticks       = 0;
    held        = 1'b0;
    recv_steady = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      ticks++;
      if (ticks % 250 == 0) recv_steady = ($urandom_range(0, 2) == 0);
      if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (!held && results_seen >= HOLD_AFTER) begin
        held       = 1'b1;
        stall_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!recv_steady) stall_left = pick_gap();
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("run limit reached with %0d results outstanding", expected_points.size());
    $display("Verification failed");
    $finish;
  end

  // Main sequence: reset, directed rows, random phases, then drain.
  initial begin
    smooth_result_t want;
    fail_count    = 0;
    results_seen  = 0;
    sender_steady = 1'b0;
    build_weights();
    width_reg   = WIDTH_RESET;
    seen_count  = 0;
    head_slot   = 0;
    pending_pts = 0;
    curve_half  = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        set_width(directed_rows[i].width);
      end else begin
        want.pt.x = directed_rows[i].want_x;
        want.pt.y = directed_rows[i].want_y;
        want.pt.t = directed_rows[i].want_t;
        want.last = directed_rows[i].want_last;
        send_point({directed_rows[i].t, directed_rows[i].y, directed_rows[i].x},
                   directed_rows[i].last, directed_rows[i].kind == ROW_TYPED, want);
      end
    end

    run_random();

    in_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
